// File: hw/rtl/s2rgb_pkg.sv
// Shared constants and types for the scalar-to-RGB color map.
package s2rgb_pkg;

   // Fixed-point format of the scalar input.
   localparam int FRACTION_BITS = 16;
   localparam int SCALAR_W      = 18;
   localparam int CHAN_W        = 8;

   // Clamped scalar holds 0 to ONE inclusive, so it needs one integer bit.
   localparam int X_W   = FRACTION_BITS + 1;
   localparam int CMP_W = ((SCALAR_W > X_W) ? SCALAR_W : X_W) + 1;
   localparam int PROD_W = X_W + 9;
   localparam int HUE_W  = X_W + 3;

   localparam logic [X_W-1:0] ONE_FX  = X_W'(1) << FRACTION_BITS;
   localparam logic [X_W-1:0] HALF_FX = X_W'(1) << (FRACTION_BITS - 1);

   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;
   localparam logic [CHAN_W-1:0] CHAN_MID = 8'd128;
   localparam logic [CHAN_W-1:0] CHAN_MIN = 8'd0;

   // Map selection held in the control register.
   typedef enum logic [1:0] {
      MAP_BLUEHOT   = 2'd0,
      MAP_DIVERGENT = 2'd1,
      MAP_RAINBOW   = 2'd2
   } map_mode_type;

   // Hue sectors of the rainbow map.
   typedef enum logic [2:0] {
      HUE_RED_YELLOW    = 3'd0,
      HUE_YELLOW_GREEN  = 3'd1,
      HUE_GREEN_CYAN    = 3'd2,
      HUE_CYAN_BLUE     = 3'd3,
      HUE_BLUE_MAGENTA  = 3'd4,
      HUE_MAGENTA_RED   = 3'd5
   } hue_sector_type;

   // One mapped color.
   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

endpackage

// File: hw/rtl/s2rgb_req_if.sv
// Request channel carrying one scalar per transaction.
interface s2rgb_req_if
   import s2rgb_pkg::*;
;
   logic                       valid;
   logic                       ready;
   logic signed [SCALAR_W-1:0] scalar_value;

   modport source (output valid, output scalar_value, input ready);
   modport sink   (input valid, input scalar_value, output ready);
endinterface

// File: hw/rtl/s2rgb_rsp_if.sv
// Response channel carrying one RGB color per transaction.
interface s2rgb_rsp_if
   import s2rgb_pkg::*;
;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// File: hw/rtl/s2rgb_core.sv
// Combinational color mapping of one scalar under the selected map.
module s2rgb_core
   import s2rgb_pkg::*;
(
   input  logic signed [SCALAR_W-1:0] scalar_value,
   input  map_mode_type               map_mode,
   output rgb_type                    rgb
);

   logic signed [CMP_W-1:0] s_ext;
   logic signed [CMP_W-1:0] one_ext;
   logic                    s_neg;
   logic                    s_over;
   logic                    s_in_unit;
   logic [X_W-1:0]          x;

   logic [PROD_W-1:0]       bh_p255;
   logic [PROD_W-1:0]       bh_p127;
   logic [CHAN_W-1:0]       bh_ramp;
   logic [CHAN_W-1:0]       bh_blue;

   logic                    dv_low;
   logic                    dv_mid;
   logic [X_W-1:0]          dv_v;
   logic [PROD_W-1:0]       dv_p510;
   logic [PROD_W-1:0]       dv_p254;
   logic [CHAN_W-1:0]       dv_a;
   logic [CHAN_W-1:0]       dv_b;

   logic [HUE_W-1:0]         hue;
   hue_sector_type           sector;
   logic [FRACTION_BITS-1:0] frac;
   logic [X_W-1:0]           frac_inv;
   logic [PROD_W-1:0]        rb_pt;
   logic [PROD_W-1:0]        rb_pq;
   logic [CHAN_W-1:0]        rb_t;
   logic [CHAN_W-1:0]        rb_q;

   // Range checks and clamp of the scalar to [0, 1].
   assign s_ext     = {{(CMP_W-SCALAR_W){scalar_value[SCALAR_W-1]}}, scalar_value};
   assign one_ext   = $signed({{(CMP_W-X_W){1'b0}}, ONE_FX});
   assign s_neg     = scalar_value[SCALAR_W-1];
   assign s_over    = (s_ext > one_ext);
   assign s_in_unit = !s_neg && (s_ext < one_ext);

   always_comb begin
      if (s_neg) begin
         x = '0;
      end else if (s_over) begin
         x = ONE_FX;
      end else begin
         x = s_ext[X_W-1:0];
      end
   end

   // Blue-hot ramp.
   assign bh_p255 = PROD_W'(x) * PROD_W'(255);
   assign bh_p127 = PROD_W'(x) * PROD_W'(127);
   assign bh_ramp = bh_p255[FRACTION_BITS +: CHAN_W];
   assign bh_blue = CHAN_MID + bh_p127[FRACTION_BITS +: CHAN_W];

   // Divergent map: both halves share one pair of products on the distance
   // from the nearer end of the range.
   assign dv_low  = (x < HALF_FX);
   assign dv_mid  = (x == HALF_FX);
   assign dv_v    = dv_low ? x : (ONE_FX - x);
   assign dv_p510 = PROD_W'(dv_v) * PROD_W'(510);
   assign dv_p254 = PROD_W'(dv_v) * PROD_W'(254);
   assign dv_a    = dv_p510[FRACTION_BITS +: CHAN_W];
   assign dv_b    = CHAN_MID + dv_p254[FRACTION_BITS +: CHAN_W];

   // Rainbow: hue is six times the scalar, split into sector and fraction.
   assign hue      = HUE_W'(x) * HUE_W'(6);
   assign sector   = hue_sector_type'(hue[FRACTION_BITS +: 3]);
   assign frac     = hue[FRACTION_BITS-1:0];
   assign frac_inv = ONE_FX - X_W'(frac);
   assign rb_pt    = PROD_W'(frac) * PROD_W'(255);
   assign rb_pq    = PROD_W'(frac_inv) * PROD_W'(255);
   assign rb_t     = rb_pt[FRACTION_BITS +: CHAN_W];
   assign rb_q     = rb_pq[FRACTION_BITS +: CHAN_W];

   // Select the color for the active map.
   always_comb begin
      rgb = '{red: CHAN_MIN, green: CHAN_MIN, blue: CHAN_MIN};
      case (map_mode)
         MAP_BLUEHOT: begin
            rgb = '{red: bh_ramp, green: bh_ramp, blue: bh_blue};
         end
         MAP_DIVERGENT: begin
            if (dv_mid) begin
               rgb = '{red: CHAN_MAX, green: CHAN_MAX, blue: CHAN_MAX};
            end else if (dv_low) begin
               rgb = '{red: dv_a, green: dv_a, blue: dv_b};
            end else begin
               rgb = '{red: dv_b, green: dv_a, blue: dv_a};
            end
         end
         MAP_RAINBOW: begin
            if (s_in_unit) begin
               case (sector)
                  HUE_RED_YELLOW:   rgb = '{red: CHAN_MAX, green: rb_t, blue: CHAN_MIN};
                  HUE_YELLOW_GREEN: rgb = '{red: rb_q, green: CHAN_MAX, blue: CHAN_MIN};
                  HUE_GREEN_CYAN:   rgb = '{red: CHAN_MIN, green: CHAN_MAX, blue: rb_t};
                  HUE_CYAN_BLUE:    rgb = '{red: CHAN_MIN, green: rb_q, blue: CHAN_MAX};
                  HUE_BLUE_MAGENTA: rgb = '{red: rb_t, green: CHAN_MIN, blue: CHAN_MAX};
                  HUE_MAGENTA_RED:  rgb = '{red: CHAN_MAX, green: CHAN_MIN, blue: rb_q};
                  default:          rgb = '{red: CHAN_MIN, green: CHAN_MIN, blue: CHAN_MIN};
               endcase
            end
         end
         default: begin
            rgb = '{red: CHAN_MIN, green: CHAN_MIN, blue: CHAN_MIN};
         end
      endcase
   end

endmodule

// File: hw/rtl/scalar_to_rgb_colormap.sv
// Top level of the scalar-to-RGB color map with its control register.
//
// Maps one signed fixed-point scalar (16 fraction bits, 65536 = 1.0) to an
// 8-bit RGB color per transaction. The control register selects blue-hot,
// divergent or HSV rainbow; write it only while no transaction is in flight.
// The block takes one scalar every clock cycle unless back-pressure holds it,
// and returns its color through the input register, then through the mapping
// logic into the output register. Back-pressure on the response side holds
// both registers, and the request side keeps accepting as long as a register
// ahead has room.
module scalar_to_rgb_colormap
   import s2rgb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_wr_data,
   s2rgb_req_if.sink           req_chan,
   s2rgb_rsp_if.source         rsp_chan
);

   map_mode_type               map_mode_ff;
   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   logic signed [SCALAR_W-1:0] s1_scalar_ff;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   rgb_type                    rsp_rgb_ff;
   rgb_type                    core_rgb;
   logic                       s1_open;
   logic                       s2_open;

   // Control register.
   always_ff @(posedge clock) begin
      if (reset) begin
         map_mode_ff <= MAP_BLUEHOT;
      end else if (csr_wr_en) begin
         map_mode_ff <= map_mode_type'(csr_wr_data);
      end
   end

   // Pipeline flow control: a stage opens when it is empty or drains.
   assign s2_open        = !rsp_valid_ff || rsp_chan.ready;
   assign s1_open        = !s1_valid_ff || s2_open;
   assign req_chan.ready = s1_open;
   assign s1_valid_in    = s1_open ? req_chan.valid : s1_valid_ff;
   assign rsp_valid_in   = s2_open ? s1_valid_ff : rsp_valid_ff;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_open && req_chan.valid) begin
         s1_scalar_ff <= req_chan.scalar_value;
      end
   end

   // Color mapping.
   s2rgb_core u_core (
      .scalar_value (s1_scalar_ff),
      .map_mode     (map_mode_ff),
      .rgb          (core_rgb)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_open && s1_valid_ff) begin
         rsp_rgb_ff <= core_rgb;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.red   = rsp_rgb_ff.red;
   assign rsp_chan.green = rsp_rgb_ff.green;
   assign rsp_chan.blue  = rsp_rgb_ff.blue;

   // An accepted transaction occupies the input register next cycle.
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> s1_valid_ff)
      else $error("accepted transaction did not reach the input register");

   // A transaction in the input register moves on when the output opens.
   a_s1_moves: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_open) |=> rsp_valid_ff)
      else $error("input register transaction was lost");

   // The output register captures the mapped color of the moving transaction.
   a_rsp_payload: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_open) |=> (rsp_rgb_ff == $past(core_rgb)))
      else $error("output register holds the wrong color");

   // A stalled input register keeps its transaction.
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_open) |=> (s1_valid_ff && $stable(s1_scalar_ff)))
      else $error("stalled input register changed");

endmodule
